// ===== hdl/shadow_memory_access_checker_macros.svh =====
// Assertion macros shared by the shadow memory access checker RTL.
// Depends on nothing; define NO_ASSERTIONS to compile the checks out.
`ifndef SHADOW_MEMORY_ACCESS_CHECKER_MACROS_SVH
`define SHADOW_MEMORY_ACCESS_CHECKER_MACROS_SVH

`ifndef NO_ASSERTIONS

// cons must hold in the same cycle as ante
`define SMAC_ASSERT_SAME_CYCLE(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// cons must hold in the cycle after ante
`define SMAC_ASSERT_NEXT_CYCLE(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define SMAC_ASSERT_SAME_CYCLE(label, clk, rst, ante, cons, msg)

`define SMAC_ASSERT_NEXT_CYCLE(label, clk, rst, ante, cons, msg)

`endif

`endif

// ===== hdl/smac_pkg.sv =====
// Shared types and constants of the shadow memory access checker.
// No dependencies; imported by every module of the block.
package smac_pkg;

   localparam int unsigned ADDR_W  = 64;
   localparam int unsigned LIMIT_W = 17;
   localparam int unsigned SIZE_W  = 4;
   localparam int unsigned MODE_W  = 2;
   localparam int unsigned ERR_W   = 2;
   localparam int unsigned GRAN_W  = ADDR_W - 3;
   localparam int unsigned CNT_W   = LIMIT_W - 3;
   localparam int unsigned DATA_W  = 64;
   localparam int unsigned PADDR_W = 4;

   localparam logic [7:0] MARK_REDZONE    = 8'hFA;
   localparam logic [7:0] MARK_FREED      = 8'hFD;
   localparam logic [7:0] MARK_POISON_MIN = 8'h80;
   localparam logic [7:0] MARK_OPEN       = 8'h00;

   localparam int unsigned        HEADER_BYTES = 8;
   localparam logic [LIMIT_W-1:0] HEADER_LEN   = LIMIT_W'(HEADER_BYTES);
   localparam logic [LIMIT_W-1:0] LIMIT_RESET  = 17'h10000;

   localparam logic [ERR_W-1:0] ERR_NONE           = 2'd0;
   localparam logic [ERR_W-1:0] ERR_OVERFLOW       = 2'd1;
   localparam logic [ERR_W-1:0] ERR_USE_AFTER_FREE = 2'd2;

   // register select is paddr[3]: registers sit 8 bytes apart
   localparam logic REG_HEAP_BASE  = 1'b0;
   localparam logic REG_HEAP_LIMIT = 1'b1;

   typedef enum logic [MODE_W-1:0] {
      MODE_CHECK   = 2'd0,
      MODE_ALLOC   = 2'd1,
      MODE_RELEASE = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      SEG_LEFT  = 2'd0,
      SEG_USER  = 2'd1,
      SEG_TAIL  = 2'd2,
      SEG_RIGHT = 2'd3
   } seg_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PREP,
      ST_DECIDE,
      ST_CHK_RD,
      ST_CHK_EV,
      ST_SETUP,
      ST_FILL,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [ADDR_W-1:0]  heap_base;
      logic [LIMIT_W-1:0] heap_limit;
   } cfg_type;

endpackage

// ===== hdl/smac_csr.sv =====
// APB-style register file: heap_base and heap_limit.
// Depends on smac_pkg; hands the settings to the engine as one struct.
module smac_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [smac_pkg::PADDR_W-1:0]  paddr,
   input  logic [smac_pkg::DATA_W-1:0]   pwdata,
   output logic [smac_pkg::DATA_W-1:0]   prdata,
   output logic                          pready,
   output smac_pkg::cfg_type             cfg
);
   import smac_pkg::*;

   logic [ADDR_W-1:0]  heap_base_ff, heap_base_in;
   logic [LIMIT_W-1:0] heap_limit_ff, heap_limit_in;
   logic               wr_en;
   logic               reg_sel;

   assign wr_en   = psel && penable && pwrite;
   assign reg_sel = paddr[3];
   assign pready  = 1'b1;

   always_comb begin
      heap_base_in  = heap_base_ff;
      heap_limit_in = heap_limit_ff;
      if (wr_en) begin
         case (reg_sel)
            REG_HEAP_BASE:  heap_base_in  = pwdata;
            REG_HEAP_LIMIT: heap_limit_in = pwdata[LIMIT_W-1:0];
            default:        heap_base_in  = heap_base_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         heap_base_ff  <= '0;
         heap_limit_ff <= LIMIT_RESET;
      end else begin
         heap_base_ff  <= heap_base_in;
         heap_limit_ff <= heap_limit_in;
      end
   end

   always_comb begin
      case (reg_sel)
         REG_HEAP_BASE:  prdata = heap_base_ff;
         REG_HEAP_LIMIT: prdata = DATA_W'(heap_limit_ff);
         default:        prdata = '0;
      endcase
   end

   assign cfg.heap_base  = heap_base_ff;
   assign cfg.heap_limit = heap_limit_ff;

endmodule

// ===== hdl/smac_shadow_mem.sv =====
// Shadow byte store: one write port, one read port, registered read data.
// Depends on smac_pkg only for the house import.
module smac_shadow_mem #(
   parameter longint unsigned DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [7:0]               wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [7:0]               rdata
);
   import smac_pkg::*;

   logic [7:0] shadow_mem [0:DEPTH-1];
   logic [7:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         shadow_mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= shadow_mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== hdl/smac_engine.sv =====
// Sequencer of the checker: clearing pass, granule check reads, fill walks
// and the result register. Depends on smac_pkg and the assertion macros.
`include "shadow_memory_access_checker_macros.svh"

module smac_engine #(
   parameter longint unsigned HEAP_BYTES    = 65536,
   parameter int unsigned     REDZONE_BYTES = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  smac_pkg::cfg_type                  cfg,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [smac_pkg::MODE_W-1:0]        req_mode,
   input  logic [smac_pkg::ADDR_W-1:0]        req_address,
   input  logic [smac_pkg::SIZE_W-1:0]        req_access_size,
   input  logic [smac_pkg::LIMIT_W-1:0]       req_length,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_violation,
   output logic [smac_pkg::ERR_W-1:0]         rsp_error_kind,
   output logic [smac_pkg::ADDR_W-1:0]        rsp_user_address,
   output logic                               mem_we,
   output logic [$clog2(HEAP_BYTES/8)-1:0]    mem_waddr,
   output logic [7:0]                         mem_wdata,
   output logic                               mem_re,
   output logic [$clog2(HEAP_BYTES/8)-1:0]    mem_raddr,
   input  logic [7:0]                         mem_rdata
);
   import smac_pkg::*;

   localparam longint unsigned    DEPTH        = HEAP_BYTES / 8;
   localparam int unsigned        AW           = $clog2(DEPTH);
   localparam logic [AW-1:0]      LAST_ENTRY   = AW'(DEPTH - 1);
   localparam logic [GRAN_W-1:0]  DEPTH_GRAN   = GRAN_W'(DEPTH);
   localparam logic [LIMIT_W-1:0] RZ_LEN       = LIMIT_W'(REDZONE_BYTES);
   localparam logic [ADDR_W-1:0]  RZ_ADDR      = ADDR_W'(REDZONE_BYTES);
   localparam logic [ADDR_W-1:0]  RELEASE_BACK = ADDR_W'(REDZONE_BYTES + HEADER_BYTES);

   state_type           state_ff, state_in;
   logic [AW-1:0]       clr_ff, clr_in;

   mode_type            mode_ff, mode_in;
   logic [ADDR_W-1:0]   addr_ff, addr_in;
   logic                addr_nz_ff, addr_nz_in;
   logic [SIZE_W-1:0]   size_ff, size_in;
   logic [LIMIT_W-1:0]  len_ff, len_in;

   logic [ADDR_W-1:0]   off_ff, off_in;
   logic                below_ff, below_in;

   logic [CNT_W-1:0]    chk_g_ff, chk_g_in;
   logic [CNT_W-1:0]    chk_end_ff, chk_end_in;
   logic [2:0]          last_lo_ff, last_lo_in;
   logic                rd_hit_ff, rd_hit_in;

   logic [ADDR_W-1:0]   base_ff, base_in;
   logic [GRAN_W-1:0]   gran_ff, gran_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [7:0]          val_ff, val_in;
   seg_type             seg_ff, seg_in;

   logic [ERR_W-1:0]    res_err_ff, res_err_in;
   logic [ADDR_W-1:0]   res_user_ff, res_user_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [ERR_W-1:0]    rsp_err_ff, rsp_err_in;
   logic [ADDR_W-1:0]   rsp_user_ff, rsp_user_in;

   logic                accept;
   logic [LIMIT_W-1:0]  off_lo;
   logic                off_hi_zero;
   logic                chk_in_range;
   logic [LIMIT_W-1:0]  chk_last;
   logic                rel_ok;
   logic [7:0]          shadow_byte;
   logic [3:0]          reach;
   logic                chk_at_end;
   logic                chk_fail;
   logic [ERR_W-1:0]    chk_kind;
   logic [GRAN_W-1:0]   chk_gran;
   logic [LIMIT_W-1:0]  seg_len;
   logic [7:0]          seg_val;
   logic                seg_partial;
   logic [LIMIT_W-1:0]  seg_span;
   logic [CNT_W-1:0]    seg_cnt;
   logic                seg_more;
   logic                gran_hit;
   logic                rsp_load;

   assign accept      = req_valid && req_ready;
   assign off_lo      = off_ff[LIMIT_W-1:0];
   assign off_hi_zero = (off_ff[ADDR_W-1:LIMIT_W] == '0);

   // access is checked only when all of its bytes lie inside the heap window
   assign chk_in_range = (size_ff != '0) && !below_ff && off_hi_zero &&
                         (off_lo <= cfg.heap_limit) &&
                         ((cfg.heap_limit - off_lo) >= LIMIT_W'(size_ff));
   assign chk_last     = off_lo + LIMIT_W'(size_ff) - LIMIT_W'(1);

   assign rel_ok = addr_nz_ff && !below_ff && off_hi_zero &&
                   (off_lo < cfg.heap_limit) && (len_ff >= HEADER_LEN);

   assign shadow_byte = rd_hit_ff ? mem_rdata : MARK_OPEN;
   assign chk_at_end  = (chk_g_ff == chk_end_ff);
   assign reach       = chk_at_end ? ({1'b0, last_lo_ff} + 4'd1) : 4'd8;
   assign chk_gran    = GRAN_W'(chk_g_ff);

   always_comb begin
      chk_fail = 1'b0;
      chk_kind = ERR_OVERFLOW;
      if (shadow_byte == MARK_OPEN) begin
         chk_fail = 1'b0;
      end else if (shadow_byte >= MARK_POISON_MIN) begin
         chk_fail = 1'b1;
         chk_kind = (shadow_byte == MARK_FREED) ? ERR_USE_AFTER_FREE : ERR_OVERFLOW;
      end else begin
         // partial granule: only the first shadow_byte bytes are open
         chk_fail = ({4'b0, reach} > shadow_byte);
      end
   end

   // span and mark of the current fill segment
   always_comb begin
      seg_partial = 1'b0;
      seg_len     = RZ_LEN;
      seg_val     = MARK_REDZONE;
      if (mode_ff == MODE_RELEASE) begin
         seg_len = len_ff - HEADER_LEN;
         seg_val = MARK_FREED;
      end else begin
         case (seg_ff)
            SEG_LEFT: begin
               seg_len = RZ_LEN;
               seg_val = MARK_REDZONE;
            end
            SEG_USER: begin
               seg_len = {len_ff[LIMIT_W-1:3], 3'b000};
               seg_val = MARK_OPEN;
            end
            SEG_TAIL: begin
               seg_len     = LIMIT_W'(len_ff[2:0]);
               seg_val     = 8'(len_ff[2:0]);
               seg_partial = 1'b1;
            end
            SEG_RIGHT: begin
               seg_len = RZ_LEN;
               seg_val = MARK_REDZONE;
            end
            default: begin
               seg_len = RZ_LEN;
               seg_val = MARK_REDZONE;
            end
         endcase
      end
   end

   assign seg_span = LIMIT_W'(base_ff[2:0]) + seg_len;
   assign seg_cnt  = seg_partial ? CNT_W'(len_ff[2:0] != 3'b000) : seg_span[LIMIT_W-1:3];
   assign seg_more = (mode_ff == MODE_ALLOC) && (seg_ff != SEG_RIGHT);
   assign gran_hit = (gran_ff < DEPTH_GRAN);
   assign rsp_load = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR:  if (clr_ff == LAST_ENTRY) state_in = ST_IDLE;
         ST_IDLE:   if (accept) state_in = ST_PREP;
         ST_PREP:   state_in = ST_DECIDE;
         ST_DECIDE: begin
            case (mode_ff)
               MODE_CHECK:   state_in = chk_in_range ? ST_CHK_RD : ST_DONE;
               MODE_ALLOC:   state_in = ST_SETUP;
               MODE_RELEASE: state_in = rel_ok ? ST_SETUP : ST_DONE;
               default:      state_in = ST_DONE;
            endcase
         end
         ST_CHK_RD: state_in = ST_CHK_EV;
         ST_CHK_EV: state_in = (chk_fail || chk_at_end) ? ST_DONE : ST_CHK_RD;
         ST_SETUP:  state_in = ST_FILL;
         ST_FILL: begin
            if (cnt_ff == '0) begin
               state_in = seg_more ? ST_SETUP : ST_DONE;
            end
         end
         ST_DONE:   if (rsp_load) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // handshake and memory port controls
   always_comb begin
      req_ready = 1'b0;
      mem_we    = 1'b0;
      mem_waddr = clr_ff;
      mem_wdata = MARK_OPEN;
      mem_re    = 1'b0;
      mem_raddr = chk_gran[AW-1:0];
      case (state_ff)
         ST_CLEAR: mem_we = 1'b1;
         ST_IDLE:  req_ready = 1'b1;
         ST_CHK_RD: mem_re = 1'b1;
         ST_FILL: begin
            // granules past the end of the store are dropped
            mem_we    = (cnt_ff != '0) && gran_hit;
            mem_waddr = gran_ff[AW-1:0];
            mem_wdata = val_ff;
         end
         default: mem_we = 1'b0;
      endcase
   end

   // datapath
   always_comb begin
      clr_in      = clr_ff;
      mode_in     = mode_ff;
      addr_in     = addr_ff;
      addr_nz_in  = addr_nz_ff;
      size_in     = size_ff;
      len_in      = len_ff;
      off_in      = off_ff;
      below_in    = below_ff;
      chk_g_in    = chk_g_ff;
      chk_end_in  = chk_end_ff;
      last_lo_in  = last_lo_ff;
      rd_hit_in   = rd_hit_ff;
      base_in     = base_ff;
      gran_in     = gran_ff;
      cnt_in      = cnt_ff;
      val_in      = val_ff;
      seg_in      = seg_ff;
      res_err_in  = res_err_ff;
      res_user_in = res_user_ff;
      case (state_ff)
         ST_CLEAR: clr_in = clr_ff + AW'(1);
         ST_IDLE: begin
            if (accept) begin
               mode_in     = mode_type'(req_mode);
               // a release works from the block start behind the header
               addr_in     = (req_mode == MODE_RELEASE) ? (req_address - RELEASE_BACK)
                                                        : req_address;
               addr_nz_in  = (req_address != '0);
               size_in     = req_access_size;
               len_in      = req_length;
               res_err_in  = ERR_NONE;
               res_user_in = '0;
            end
         end
         ST_PREP: {below_in, off_in} = {1'b0, addr_ff} - {1'b0, cfg.heap_base};
         ST_DECIDE: begin
            chk_g_in   = off_lo[LIMIT_W-1:3];
            chk_end_in = chk_last[LIMIT_W-1:3];
            last_lo_in = chk_last[2:0];
            seg_in     = SEG_LEFT;
            base_in    = (mode_ff == MODE_RELEASE) ? (off_ff + ADDR_W'(HEADER_BYTES)) : off_ff;
            if (mode_ff == MODE_ALLOC) begin
               res_user_in = addr_ff + RZ_ADDR;
            end
         end
         ST_CHK_RD: rd_hit_in = (chk_gran < DEPTH_GRAN);
         ST_CHK_EV: begin
            if (chk_fail) begin
               res_err_in = chk_kind;
            end else if (!chk_at_end) begin
               chk_g_in = chk_g_ff + CNT_W'(1);
            end
         end
         ST_SETUP: begin
            gran_in = base_ff[ADDR_W-1:3];
            cnt_in  = seg_cnt;
            val_in  = seg_val;
            base_in = base_ff + ADDR_W'(seg_len);
         end
         ST_FILL: begin
            if (cnt_ff != '0) begin
               gran_in = gran_ff + GRAN_W'(1);
               cnt_in  = cnt_ff - CNT_W'(1);
            end else if (seg_more) begin
               seg_in = seg_type'(seg_ff + 2'd1);
            end
         end
         default: clr_in = clr_ff;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_err_in   = rsp_err_ff;
      rsp_user_in  = rsp_user_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_err_in   = res_err_ff;
         rsp_user_in  = res_user_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      addr_ff     <= addr_in;
      addr_nz_ff  <= addr_nz_in;
      size_ff     <= size_in;
      len_ff      <= len_in;
      off_ff      <= off_in;
      below_ff    <= below_in;
      chk_g_ff    <= chk_g_in;
      chk_end_ff  <= chk_end_in;
      last_lo_ff  <= last_lo_in;
      rd_hit_ff   <= rd_hit_in;
      base_ff     <= base_in;
      gran_ff     <= gran_in;
      cnt_ff      <= cnt_in;
      val_ff      <= val_in;
      seg_ff      <= seg_in;
      res_err_ff  <= res_err_in;
      res_user_ff <= res_user_in;
      rsp_err_ff  <= rsp_err_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_error_kind   = rsp_err_ff;
   assign rsp_violation    = (rsp_err_ff != ERR_NONE);
   assign rsp_user_address = rsp_user_ff;

   `SMAC_ASSERT_SAME_CYCLE(a_check_no_write, clock, reset,
      (state_ff == ST_CHK_RD || state_ff == ST_CHK_EV), !mem_we,
      "shadow write during a check transaction")
   `SMAC_ASSERT_SAME_CYCLE(a_check_gran_bound, clock, reset,
      (state_ff == ST_CHK_RD), (chk_g_ff <= chk_end_ff),
      "check read past the last touched granule")
   `SMAC_ASSERT_NEXT_CYCLE(a_fill_count_down, clock, reset,
      (state_ff == ST_FILL && cnt_ff != '0), (cnt_ff == $past(cnt_ff) - CNT_W'(1)),
      "fill walk count did not step down")
   `SMAC_ASSERT_NEXT_CYCLE(a_one_in_flight, clock, reset,
      (req_valid && req_ready), !req_ready,
      "second transaction taken while one is in flight")

endmodule

// ===== hdl/shadow_memory_access_checker.sv =====
// Shadow memory access checker: one shadow byte per 8-byte heap granule in a synchronous
// store (HEAP_BYTES/8 entries) with one write port and one read port. After reset a
// clearing pass writes the whole store to zero with req_ready low; register writes are
// taken throughout. One transaction is processed at a time, paced by the store's single
// write port. A check reads and then evaluates each of its G = 1..3 touched granules in
// turn, stopping at the first violation, into a registered result. An allocate walks four
// segments (left red zone, whole user granules, tail granule, right red zone) at one
// shadow write per cycle, with a setup step before each segment. A release writes about
// length/8 granules. The result register lets the next transaction be accepted while a
// result waits on rsp_ready.
// Depends on smac_pkg, smac_csr, smac_shadow_mem and smac_engine.
module shadow_memory_access_checker #(
   parameter longint unsigned HEAP_BYTES    = 65536,
   parameter int unsigned     REDZONE_BYTES = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [smac_pkg::MODE_W-1:0]   req_mode,
   input  logic [smac_pkg::ADDR_W-1:0]   req_address,
   input  logic [smac_pkg::SIZE_W-1:0]   req_access_size,
   input  logic [smac_pkg::LIMIT_W-1:0]  req_length,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_violation,
   output logic [smac_pkg::ERR_W-1:0]    rsp_error_kind,
   output logic [smac_pkg::ADDR_W-1:0]   rsp_user_address,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [smac_pkg::PADDR_W-1:0]  paddr,
   input  logic [smac_pkg::DATA_W-1:0]   pwdata,
   output logic [smac_pkg::DATA_W-1:0]   prdata,
   output logic                          pready
);
   import smac_pkg::*;

   localparam longint unsigned DEPTH = HEAP_BYTES / 8;
   localparam int unsigned     AW    = $clog2(DEPTH);

   cfg_type       cfg;
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [7:0]    mem_wdata;
   logic          mem_re;
   logic [AW-1:0] mem_raddr;
   logic [7:0]    mem_rdata;

   smac_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   smac_shadow_mem #(
      .DEPTH (DEPTH)
   ) u_shadow_mem (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   smac_engine #(
      .HEAP_BYTES    (HEAP_BYTES),
      .REDZONE_BYTES (REDZONE_BYTES)
   ) u_engine (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_address      (req_address),
      .req_access_size  (req_access_size),
      .req_length       (req_length),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_violation    (rsp_violation),
      .rsp_error_kind   (rsp_error_kind),
      .rsp_user_address (rsp_user_address),
      .mem_we           (mem_we),
      .mem_waddr        (mem_waddr),
      .mem_wdata        (mem_wdata),
      .mem_re           (mem_re),
      .mem_raddr        (mem_raddr),
      .mem_rdata        (mem_rdata)
   );

endmodule

// ===== tb/tb_shadow_memory_access_checker.sv =====
// Self-checking testbench for shadow_memory_access_checker: directed table, then random
// allocate/check/release traffic under several heap windows, scored against a shadow model.
// Depends on smac_pkg and the shadow_memory_access_checker RTL.
module tb_shadow_memory_access_checker;
   timeunit 1ns;
   timeprecision 1ps;

   import smac_pkg::*;

   localparam int unsigned       SHADOW_ENTRIES  = 8192;
   localparam logic [63:0]       RED_ZONE_BYTES  = 64'd16;
   localparam logic [MODE_W-1:0] MODE_UNUSED     = 2'd3;
   localparam int unsigned       ITEMS_PER_PHASE = 160;
   localparam int unsigned       PHASE_COUNT     = 7;
   localparam int unsigned       LONG_HOLD       = 400;
   localparam bit                TYPED           = 1'b1;
   localparam bit                PREDICTED       = 1'b0;

   typedef struct packed {
      logic [MODE_W-1:0]  mode;
      logic [ADDR_W-1:0]  address;
      logic [SIZE_W-1:0]  access_size;
      logic [LIMIT_W-1:0] length;
   } req_item_t;

   typedef struct packed {
      logic               violation;
      logic [ERR_W-1:0]   error_kind;
      logic [ADDR_W-1:0]  user_address;
   } verdict_t;

   typedef struct packed {
      req_item_t item;
      logic      typed;
      verdict_t  want;
   } dir_row_t;

   typedef struct packed {
      logic [63:0]        offset;
      logic [LIMIT_W-1:0] length;
   } live_block_t;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [MODE_W-1:0]   req_mode = '0;
   logic [ADDR_W-1:0]   req_address = '0;
   logic [SIZE_W-1:0]   req_access_size = '0;
   logic [LIMIT_W-1:0]  req_length = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic                rsp_violation;
   logic [ERR_W-1:0]    rsp_error_kind;
   logic [ADDR_W-1:0]   rsp_user_address;
   logic                psel = 1'b0;
   logic                penable = 1'b0;
   logic                pwrite = 1'b0;
   logic [PADDR_W-1:0]  paddr = '0;
   logic [DATA_W-1:0]   pwdata = '0;
   logic [DATA_W-1:0]   prdata;
   logic                pready;

   // shadow model state and its copy of the registers
   logic [7:0]  shadow_model [SHADOW_ENTRIES];
   logic [63:0] model_base;
   logic [63:0] model_limit;

   verdict_t    pending_verdicts [$];
   live_block_t live_blocks [$];

   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int unsigned long_hold_cycles = 0;
   int unsigned mismatch_count = 0;
   int unsigned results_checked = 0;
   int unsigned uaf_seen = 0;
   int unsigned overflow_seen = 0;
   int unsigned heap_settings = 0;
   int unsigned mode_count [4] = '{0, 0, 0, 0};

   shadow_memory_access_checker dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_address      (req_address),
      .req_access_size  (req_access_size),
      .req_length       (req_length),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_violation    (rsp_violation),
      .rsp_error_kind   (rsp_error_kind),
      .rsp_user_address (rsp_user_address),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ---------------------------------------------------------------- shadow model

   function automatic void mark_granules(logic [63:0] off, logic [63:0] n, logic [7:0] mark);
      logic [63:0] first;
      logic [63:0] cnt;
      logic [63:0] k;
      logic [63:0] g;
      first = off >> 3;
      cnt = ((off & 64'd7) + n) >> 3;
      for (k = 0; k < cnt; k++) begin
         // granule index wraps at 2^61
         g = (first + k) & 64'h1FFF_FFFF_FFFF_FFFF;
         if (g < SHADOW_ENTRIES) shadow_model[g[12:0]] = mark;
      end
   endfunction

   function automatic void unpoison_bytes(logic [63:0] off, logic [63:0] n);
      logic [63:0] whole;
      logic [63:0] g;
      whole = n & ~64'd7;
      mark_granules(off, whole, MARK_OPEN);
      if (n[2:0] != 3'd0) begin
         g = (off + whole) >> 3;
         if (g < SHADOW_ENTRIES) shadow_model[g[12:0]] = {5'd0, n[2:0]};
      end
   endfunction

   function automatic logic [ERR_W-1:0] classify_access(logic [63:0] a, logic [SIZE_W-1:0] size);
      logic [63:0] off;
      logic [63:0] last;
      logic [63:0] g;
      logic [63:0] g_end;
      logic [63:0] reach;
      logic [7:0]  s;
      if (size == 0 || a < model_base) return ERR_NONE;
      off = a - model_base;
      if (off > model_limit || model_limit - off < 64'(size)) return ERR_NONE;
      last = off + 64'(size) - 64'd1;
      g_end = last >> 3;
      for (g = off >> 3; g <= g_end; g++) begin
         s = (g < SHADOW_ENTRIES) ? shadow_model[g[12:0]] : MARK_OPEN;
         if (s == MARK_OPEN) continue;
         if (s >= MARK_POISON_MIN)
            return (s == MARK_FREED) ? ERR_USE_AFTER_FREE : ERR_OVERFLOW;
         // partial granule: only the last granule may stop short of byte 8
         reach = (g == g_end) ? (last & 64'd7) + 64'd1 : 64'd8;
         if (reach > 64'(s)) return ERR_OVERFLOW;
      end
      return ERR_NONE;
   endfunction

   function automatic verdict_t shadow_verdict(req_item_t it);
      verdict_t    v;
      logic [63:0] raw_off;
      logic [63:0] blk;
      logic [63:0] len;
      v = '0;
      len = 64'(it.length);
      case (it.mode)
         MODE_CHECK: begin
            v.error_kind = classify_access(it.address, it.access_size);
         end
         MODE_ALLOC: begin
            raw_off = it.address - model_base;
            mark_granules(raw_off, RED_ZONE_BYTES, MARK_REDZONE);
            unpoison_bytes(raw_off + RED_ZONE_BYTES, len);
            mark_granules(raw_off + RED_ZONE_BYTES + len, RED_ZONE_BYTES, MARK_REDZONE);
            v.user_address = it.address + RED_ZONE_BYTES;
         end
         MODE_RELEASE: begin
            blk = it.address - RED_ZONE_BYTES - 64'(HEADER_BYTES);
            if (it.address != 0 && blk >= model_base && blk - model_base < model_limit &&
                len >= 64'(HEADER_BYTES))
               mark_granules(blk - model_base + 64'(HEADER_BYTES), len - 64'(HEADER_BYTES),
                             MARK_FREED);
         end
         default: ;
      endcase
      v.violation = (v.error_kind != ERR_NONE);
      return v;
   endfunction

   // ---------------------------------------------------------------- stimulus helpers

   function automatic dir_row_t dir_row(logic [MODE_W-1:0] m, logic [63:0] a,
                                        logic [SIZE_W-1:0] sz, logic [LIMIT_W-1:0] len,
                                        logic typed, logic [ERR_W-1:0] err,
                                        logic [63:0] user);
      dir_row_t r;
      r.item  = '{mode: m, address: a, access_size: sz, length: len};
      r.typed = typed;
      r.want  = '{violation: (err != ERR_NONE), error_kind: err, user_address: user};
      return r;
   endfunction

   function automatic logic [LIMIT_W-1:0] pick_length();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 50) return LIMIT_W'($urandom_range(0, 64));
      if (r < 90) return LIMIT_W'($urandom_range(0, 600));
      if (r < 98) return LIMIT_W'($urandom_range(0, 4096));
      return LIMIT_W'($urandom_range(0, 131071));
   endfunction

   // mostly allocate / probe / release on live blocks, some raw noise
   function automatic req_item_t random_item();
      req_item_t   it;
      live_block_t b;
      int unsigned roll;
      int unsigned span;
      int unsigned idx;
      longint      delta;
      it.mode = MODE_CHECK;
      it.address = '0;
      it.access_size = SIZE_W'($urandom_range(0, 15));
      it.length = LIMIT_W'($urandom_range(0, 600));
      span = int'(model_limit[31:0]) + 64;
      roll = $urandom_range(99);
      if (live_blocks.size() == 0 && roll >= 20 && roll < 80) roll = 0;
      if (roll < 20) begin
         b.offset = 64'($urandom_range(0, span));
         if ($urandom_range(3) != 0) b.offset[2:0] = 3'b000;
         b.length = pick_length();
         live_blocks.push_back(b);
         if (live_blocks.size() > 12) void'(live_blocks.pop_front());
         it.mode = MODE_ALLOC;
         it.address = model_base + b.offset;
         it.length = b.length;
      end else if (roll < 65) begin
         b = live_blocks[$urandom_range(0, live_blocks.size() - 1)];
         delta = longint'($urandom_range(0, int'(b.length) + 48)) - 24;
         it.address = model_base + b.offset + RED_ZONE_BYTES + delta;
         if ($urandom_range(9) < 7) it.access_size = SIZE_W'(1 << $urandom_range(0, 3));
      end else if (roll < 80) begin
         idx = $urandom_range(0, live_blocks.size() - 1);
         b = live_blocks[idx];
         live_blocks.delete(idx);
         it.mode = MODE_RELEASE;
         it.address = model_base + b.offset + RED_ZONE_BYTES;
         // header + both red zones + user bytes, sometimes a corrupt header
         it.length = ($urandom_range(9) != 0) ? LIMIT_W'(b.length + 40)
                                              : LIMIT_W'($urandom_range(0, 64));
      end else begin
         it.mode = MODE_W'($urandom_range(0, 3));
         it.address = $urandom_range(1) ? {$urandom, $urandom}
                                        : model_base + 64'($urandom_range(0, span));
         it.length = pick_length();
      end
      return it;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      mismatch_count++;
      if (mismatch_count <= 40)
         $display("tb: %s mismatch at %0t: got %h, want %h", what, $time, got, want);
   endtask

   task automatic csr_write(input logic sel, input logic [63:0] value);
      paddr   <= {sel, 3'b000};
      pwdata  <= value;
      pwrite  <= 1'b1;
      psel    <= 1'b1;
      penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (sel == REG_HEAP_BASE) model_base = value;
      else model_limit = value & 64'h1FFFF;
   endtask

   // called at a rising edge; leaves valid high so the next call can follow back to back
   task automatic send_item(input req_item_t it, input logic typed, input verdict_t want);
      verdict_t v;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_mode        <= it.mode;
      req_address     <= it.address;
      req_access_size <= it.access_size;
      req_length      <= it.length;
      do @(posedge clock); while (!req_ready);
      v = shadow_verdict(it);
      pending_verdicts.push_back(typed ? want : v);
      mode_count[it.mode]++;
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_verdicts.size() != 0);
      repeat (2) @(posedge clock);
   endtask

   // ---------------------------------------------------------------- result side

   initial begin
      verdict_t    want;
      int unsigned hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            if (pending_verdicts.size() == 0) begin
               report_mismatch("unexpected transaction", rsp_user_address, '0);
            end else begin
               want = pending_verdicts.pop_front();
               results_checked++;
               if (want.error_kind == ERR_USE_AFTER_FREE) uaf_seen++;
               if (want.error_kind == ERR_OVERFLOW) overflow_seen++;
               if (rsp_violation !== want.violation)
                  report_mismatch("violation", 64'(rsp_violation), 64'(want.violation));
               if (rsp_error_kind !== want.error_kind)
                  report_mismatch("error_kind", 64'(rsp_error_kind), 64'(want.error_kind));
               if (rsp_user_address !== want.user_address)
                  report_mismatch("user_address", rsp_user_address, want.user_address);
            end
         end
         if (long_hold_cycles != 0) begin
            hold_left = long_hold_cycles;
            long_hold_cycles = 0;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // ---------------------------------------------------------------- stimulus

   initial begin
      dir_row_t    directed_rows [$];
      logic [63:0] base_val;
      logic [63:0] limit_val;
      int unsigned phase;
      int unsigned n;

      foreach (shadow_model[i]) shadow_model[i] = MARK_OPEN;
      model_base  = '0;
      model_limit = 64'(LIMIT_RESET);

      directed_rows = '{
         dir_row(MODE_CHECK,   64'h0,    4'd1,  17'd0,     TYPED, ERR_NONE, 64'h0),
         dir_row(MODE_CHECK,   64'h1000, 4'd0,  17'd0,     TYPED, ERR_NONE, 64'h0),
         dir_row(MODE_CHECK,   64'hFFFF, 4'd1,  17'd0,     TYPED, ERR_NONE, 64'h0),
         dir_row(MODE_CHECK,   64'hFFFF, 4'd2,  17'd0,     TYPED, ERR_NONE, 64'h0),
         dir_row(MODE_CHECK,   '1,       4'd15, 17'd0,     TYPED, ERR_NONE, 64'h0),
         dir_row(MODE_ALLOC,   64'h100,  4'd0,  17'd16,    TYPED, ERR_NONE, 64'h110),
         dir_row(MODE_CHECK,   64'h110,  4'd8,  17'd0,     TYPED, ERR_NONE, 64'h0),
         dir_row(MODE_CHECK,   64'h108,  4'd1,  17'd0,     TYPED, ERR_OVERFLOW, 64'h0),
         dir_row(MODE_CHECK,   64'h120,  4'd4,  17'd0,     TYPED, ERR_OVERFLOW, 64'h0),
         dir_row(MODE_CHECK,   64'h11C,  4'd8,  17'd0,     TYPED, ERR_OVERFLOW, 64'h0),
         dir_row(MODE_RELEASE, 64'h110,  4'd0,  17'd40,    TYPED, ERR_NONE, 64'h0),
         dir_row(MODE_CHECK,   64'h110,  4'd1,  17'd0,     TYPED, ERR_USE_AFTER_FREE, 64'h0),
         dir_row(MODE_CHECK,   64'h120,  4'd1,  17'd0,     TYPED, ERR_OVERFLOW, 64'h0),
         dir_row(MODE_ALLOC,   64'h200,  4'd0,  17'd13,    TYPED, ERR_NONE, 64'h210),
         dir_row(MODE_CHECK,   64'h210,  4'd13, 17'd0,     PREDICTED, ERR_NONE, 64'h0),
         dir_row(MODE_CHECK,   64'h218,  4'd4,  17'd0,     PREDICTED, ERR_NONE, 64'h0),
         dir_row(MODE_ALLOC,   64'h300,  4'd0,  17'd0,     TYPED, ERR_NONE, 64'h310),
         dir_row(MODE_RELEASE, 64'h0,    4'd0,  17'd40,    TYPED, ERR_NONE, 64'h0),
         dir_row(MODE_RELEASE, 64'h310,  4'd0,  17'd7,     TYPED, ERR_NONE, 64'h0),
         dir_row(MODE_RELEASE, 64'h10,   4'd0,  17'd100,   TYPED, ERR_NONE, 64'h0),
         dir_row(MODE_UNUSED,  '1,       4'd15, 17'h1FFFF, TYPED, ERR_NONE, 64'h0),
         // raw offset wraps the top of the address space, then opens almost everything
         dir_row(MODE_ALLOC,   '1,       4'd0,  17'h1FFFF, TYPED, ERR_NONE, 64'hF),
         dir_row(MODE_CHECK,   64'h0,    4'd8,  17'd0,     PREDICTED, ERR_NONE, 64'h0),
         dir_row(MODE_RELEASE, 64'h30,   4'd0,  17'h1FFFF, TYPED, ERR_NONE, 64'h0),
         dir_row(MODE_CHECK,   64'h40,   4'd1,  17'd0,     TYPED, ERR_USE_AFTER_FREE, 64'h0)
      };

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // registers are taken while the store clears
      send_idle_pct = 28;
      recv_idle_pct = 80;
      csr_write(REG_HEAP_BASE, 64'h0);
      csr_write(REG_HEAP_LIMIT, 64'(LIMIT_RESET));
      heap_settings++;
      foreach (directed_rows[i])
         send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
      drain_results();

      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0: begin base_val = 64'h0; limit_val = 64'd65536; end
            1: begin base_val = {$urandom, $urandom} & ~64'h7; limit_val = 64'd4096; end
            2: begin base_val = {$urandom, $urandom}; limit_val = 64'd131071; end
            3: begin base_val = 64'hFFFF_FFFF_FFFF_C000; limit_val = 64'd65536; end
            4: begin base_val = {$urandom, $urandom}; limit_val = 64'd0; end
            5: begin base_val = '1; limit_val = 64'd1; end
            default: begin
               base_val  = {$urandom, $urandom};
               limit_val = 64'($urandom_range(0, 131071));
            end
         endcase
         send_idle_pct = (phase < 3) ? 28 : (phase < 5) ? 80 : 0;
         recv_idle_pct = (phase < 3) ? 80 : (phase < 5) ? 28 : 0;
         csr_write(REG_HEAP_BASE, base_val);
         csr_write(REG_HEAP_LIMIT, limit_val);
         heap_settings++;
         live_blocks.delete();
         for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            // receiver backs off long enough for the input side to stall
            if ((phase == 0 || phase == 3) && n == 50) long_hold_cycles = LONG_HOLD;
            if (phase == 5 && n == 80) drain_results();
            send_item(random_item(), PREDICTED, '0);
         end
         drain_results();
      end

      repeat (20) @(posedge clock);
      $display("tb: %0d transactions (%0d check, %0d allocate, %0d release, %0d unused) over %0d heap windows",
               mode_count[0] + mode_count[1] + mode_count[2] + mode_count[3],
               mode_count[0], mode_count[1], mode_count[2], mode_count[3], heap_settings);
      $display("tb: %0d results compared, %0d expected overflows, %0d expected use-after-free",
               results_checked, overflow_seen, uaf_seen);
      if (mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #48_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule

// ===== shadow_memory_access_checker.f =====
+incdir+hdl
hdl/smac_pkg.sv
hdl/smac_csr.sv
hdl/smac_shadow_mem.sv
hdl/smac_engine.sv
hdl/shadow_memory_access_checker.sv
tb/tb_shadow_memory_access_checker.sv
